// ----- hw/rtl/tfpa_pkg.sv -----
// tfpa_pkg: shared types, codes and reset layout for the typed fit partition allocator
// depends on nothing; imported by typed_fit_partition_allocator and its bench
`timescale 1ns / 1ps

package tfpa_pkg;

   // default sizing of the partition table and its reset layout
   localparam int TABLE_DEPTH_DEF  = 32;
   localparam int LARGE_COUNT_DEF  = 4;
   localparam int MEDIUM_COUNT_DEF = 4;
   localparam int SMALL_COUNT_DEF  = 12;

   // sizes of the reset layout pools
   localparam logic [5:0] LARGE_UNITS  = 6'd3;
   localparam logic [5:0] MEDIUM_UNITS = 6'd2;
   localparam logic [5:0] SMALL_UNITS  = 6'd1;
   localparam logic [5:0] UNITS_MAX    = 6'd63;

   // pool type codes
   localparam logic [1:0] POOL_LARGE  = 2'd0;
   localparam logic [1:0] POOL_MEDIUM = 2'd1;
   localparam logic [1:0] POOL_SMALL  = 2'd2;

   // fit strategy codes (anything else behaves as worst fit)
   localparam logic [1:0] FIT_BEST  = 2'd0;
   localparam logic [1:0] FIT_FIRST = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // request action codes
   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // response status codes
   localparam logic [1:0] STAT_ALLOCATED = 2'd0;
   localparam logic [1:0] STAT_NO_FIT    = 2'd1;
   localparam logic [1:0] STAT_RELEASED  = 2'd2;
   localparam logic [1:0] STAT_NO_OWNER  = 2'd3;

   // one table entry as held in the memory
   typedef struct packed {
      logic [1:0]  pool;
      logic [5:0]  units;
      logic        free;
      logic [15:0] owner;
   } tbl_entry_type;

   // entry k of the reset layout: large, then medium, then small, then empty
   function automatic tbl_entry_type init_entry(int k, int n_large, int n_medium,
                                                int n_small);
      tbl_entry_type e;
      e.free  = 1'b1;
      e.owner = 16'd0;
      if (k < n_large) begin
         e.pool  = POOL_LARGE;
         e.units = LARGE_UNITS;
      end else if (k < n_large + n_medium) begin
         e.pool  = POOL_MEDIUM;
         e.units = MEDIUM_UNITS;
      end else if (k < n_large + n_medium + n_small) begin
         e.pool  = POOL_SMALL;
         e.units = SMALL_UNITS;
      end else begin
         e.pool  = POOL_LARGE;
         e.units = 6'd0;
      end
      return e;
   endfunction

endpackage

// ----- hw/rtl/typed_fit_partition_allocator.sv -----
// typed_fit_partition_allocator: partition table in one synchronous memory with a scan sequencer
// depends on tfpa_pkg (entry type, codes, reset layout function)
// allocate: a scan of count entries, one read each, then a write of the chosen entry if one fits;
//   release: an owner scan, then a merge/compaction pass over the live entries
// throughput: one request at a time; count is the live table length (20 after reset)
// reset: synchronous; requests wait out a layout pass writing TABLE_DEPTH entries, one a cycle
`timescale 1ns / 1ps

module typed_fit_partition_allocator
   import tfpa_pkg::*;
#(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int LARGE_COUNT  = LARGE_COUNT_DEF,
   parameter int MEDIUM_COUNT = MEDIUM_COUNT_DEF,
   parameter int SMALL_COUNT  = SMALL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [1:0]  req_pool_type,
   input  logic [5:0]  req_units_needed,
   input  logic [15:0] req_owner_id,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_entry_index,
   output logic [5:0]  rsp_entry_size,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_fit_strategy
);

   localparam int IW        = $clog2(TABLE_DEPTH);
   localparam int CW        = $clog2(TABLE_DEPTH + 1);
   localparam int LayoutN   = LARGE_COUNT + MEDIUM_COUNT + SMALL_COUNT;
   localparam int InitCount = (LayoutN < TABLE_DEPTH) ? LayoutN : TABLE_DEPTH;

   // sequencer states
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MERGE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] iss_ptr_ff, iss_ptr_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          found_ff, found_in;
   logic          pend_ok_ff, pend_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    strategy_ff, strategy_in;

   // payload state
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [5:0]    best_units_ff, best_units_in;
   tbl_entry_type pend_ff, pend_in;
   logic          act_ff, act_in;
   logic [1:0]    type_ff, type_in;
   logic [5:0]    need_ff, need_in;
   logic [15:0]   owner_ff, owner_in;
   logic [1:0]    stat_ff, stat_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [4:0]    rsp_index_ff, rsp_index_in;
   logic [5:0]    rsp_size_ff, rsp_size_in;

   // table memory
   tbl_entry_type mem [TABLE_DEPTH];
   tbl_entry_type mem_rd_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   tbl_entry_type mem_wdata;
   logic [IW-1:0] mem_raddr;

   // helpers for the scan and merge stages
   tbl_entry_type rd_entry;
   logic          iss_more;
   logic          fits;
   logic          owner_hit;
   logic [6:0]    merge_sum;

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_size  = rsp_size_ff;

   assign iss_more  = (iss_ptr_ff < count_ff);
   assign mem_raddr = iss_ptr_ff[IW-1:0];

   // read data, with the released entry seen as free during the merge pass
   always_comb begin
      rd_entry = mem_rd_ff;
      if (state_ff == ST_MERGE && rd_idx_ff == best_idx_ff) begin
         rd_entry.free  = 1'b1;
         rd_entry.owner = 16'd0;
      end
   end

   assign fits      = rd_entry.free && (rd_entry.pool == type_ff) && (rd_entry.units >= need_ff);
   assign owner_hit = !rd_entry.free && (owner_ff != 16'd0) && (rd_entry.owner == owner_ff);
   assign merge_sum = {1'b0, pend_ff.units} + {1'b0, rd_entry.units};

   // synchronous memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      iss_ptr_in    = iss_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      rd_vld_in     = 1'b0;
      found_in      = found_ff;
      pend_ok_in    = pend_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      strategy_in   = strategy_ff;
      rd_idx_in     = iss_ptr_ff[IW-1:0];
      best_idx_in   = best_idx_ff;
      best_units_in = best_units_ff;
      pend_in       = pend_ff;
      act_in        = act_ff;
      type_in       = type_ff;
      need_in       = need_ff;
      owner_in      = owner_ff;
      stat_in       = stat_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_size_in   = rsp_size_ff;
      mem_we        = 1'b0;
      mem_waddr     = iss_ptr_ff[IW-1:0];
      mem_wdata     = init_entry(int'(iss_ptr_ff), LARGE_COUNT, MEDIUM_COUNT, SMALL_COUNT);

      // configuration beat
      if (csr_valid) begin
         strategy_in = csr_fit_strategy;
      end

      case (state_ff)
         // write the reset layout, one entry per cycle
         ST_INIT: begin
            mem_we     = 1'b1;
            iss_ptr_in = iss_ptr_ff + CW'(1);
            if (iss_ptr_ff == CW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take a request beat
         ST_IDLE: begin
            if (req_valid) begin
               act_in     = req_action;
               type_in    = req_pool_type;
               need_in    = req_units_needed;
               owner_in   = req_owner_id;
               found_in   = 1'b0;
               iss_ptr_in = '0;
               state_in   = ST_SCAN;
            end
         end

         // search pass: one read issued and one entry judged per cycle
         ST_SCAN: begin
            if (iss_more) begin
               rd_vld_in  = 1'b1;
               iss_ptr_in = iss_ptr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (act_ff == ACT_ALLOC) begin
                  if (fits) begin
                     if (!found_ff) begin
                        found_in      = 1'b1;
                        best_idx_in   = rd_idx_ff;
                        best_units_in = rd_entry.units;
                     end else if (strategy_ff == FIT_BEST) begin
                        if (rd_entry.units < best_units_ff) begin
                           best_idx_in   = rd_idx_ff;
                           best_units_in = rd_entry.units;
                        end
                     end else if (strategy_ff != FIT_FIRST) begin
                        if (rd_entry.units > best_units_ff) begin
                           best_idx_in   = rd_idx_ff;
                           best_units_in = rd_entry.units;
                        end
                     end
                  end
               end else if (owner_hit && !found_ff) begin
                  found_in      = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_units_in = rd_entry.units;
               end
            end
            if (!iss_more && !rd_vld_ff) begin
               if (act_ff == ACT_ALLOC) begin
                  state_in = ST_DONE;
                  if (found_ff) begin
                     stat_in         = STAT_ALLOCATED;
                     mem_we          = 1'b1;
                     mem_waddr       = best_idx_ff;
                     mem_wdata.pool  = type_ff;
                     mem_wdata.units = best_units_ff;
                     mem_wdata.free  = 1'b0;
                     mem_wdata.owner = owner_ff;
                  end else begin
                     stat_in = STAT_NO_FIT;
                  end
               end else if (found_ff) begin
                  stat_in    = STAT_RELEASED;
                  iss_ptr_in = '0;
                  wr_ptr_in  = '0;
                  pend_ok_in = 1'b0;
                  state_in   = ST_MERGE;
               end else begin
                  stat_in  = STAT_NO_OWNER;
                  state_in = ST_DONE;
               end
            end
         end

         // compaction pass: fold runs of free same-type entries, write behind the reads
         ST_MERGE: begin
            if (iss_more) begin
               rd_vld_in  = 1'b1;
               iss_ptr_in = iss_ptr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (!pend_ok_ff) begin
                  pend_in    = rd_entry;
                  pend_ok_in = 1'b1;
               end else if (pend_ff.free && rd_entry.free && pend_ff.pool == rd_entry.pool) begin
                  pend_in.units = (merge_sum > {1'b0, UNITS_MAX}) ? UNITS_MAX : merge_sum[5:0];
               end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = wr_ptr_ff[IW-1:0];
                  mem_wdata  = pend_ff;
                  wr_ptr_in  = wr_ptr_ff + CW'(1);
                  pend_in    = rd_entry;
               end
            end
            if (!iss_more && !rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr_ff[IW-1:0];
               mem_wdata = pend_ff;
               count_in  = wr_ptr_ff + CW'(1);
               state_in  = ST_DONE;
            end
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_index_in  = found_ff ? 5'(best_idx_ff) : 5'd0;
               rsp_size_in   = found_ff ? best_units_ff : 6'd0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         iss_ptr_ff   <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= CW'(InitCount);
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         pend_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         strategy_ff  <= FIT_BEST;
      end else begin
         state_ff     <= state_in;
         iss_ptr_ff   <= iss_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         pend_ok_ff   <= pend_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         strategy_ff  <= strategy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_units_ff <= best_units_in;
      pend_ff       <= pend_in;
      act_ff        <= act_in;
      type_ff       <= type_in;
      need_ff       <= need_in;
      owner_ff      <= owner_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_size_ff   <= rsp_size_in;
   end

endmodule

// ----- bench/tb_typed_fit_partition_allocator.sv -----
// tb_typed_fit_partition_allocator: self-checking bench for the typed fit partition allocator
// depends on tfpa_pkg (codes, layout sizes) and typed_fit_partition_allocator
// keeps its own copy of the partition table to predict every response beat
`timescale 1ns / 1ps

module tb_typed_fit_partition_allocator;
   import tfpa_pkg::*;

   localparam int         DEPTH           = TABLE_DEPTH_DEF;
   localparam logic [1:0] FIT_CODE_THREE  = 2'd3;  // spare code, behaves as worst fit
   localparam logic [1:0] POOL_NONE       = 2'd3;  // no entry ever has this pool type
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         DRAIN_CYCLES    = 100;
   localparam int         CYCLE_LIMIT     = 800000;
   localparam int         MAX_REPORTS     = 10;

   // one response beat as predicted
   typedef struct {
      logic [1:0] status;
      logic [4:0] index;
      logic [5:0] size;
   } alloc_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [1:0]  req_pool_type;
   logic [5:0]  req_units_needed;
   logic [15:0] req_owner_id;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_entry_index;
   logic [5:0]  rsp_entry_size;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_fit_strategy;

   // predicted partition table
   logic [1:0]  tbl_pool  [DEPTH];
   logic [5:0]  tbl_units [DEPTH];
   logic        tbl_free  [DEPTH];
   logic [15:0] tbl_owner [DEPTH];
   int          tbl_count;
   logic [1:0]  fit_mode;

   alloc_result_type pending_results[$];
   logic [15:0]      held_owners[$];

   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_off_count;
   int hold_off_seen;
   int hold_off_left;
   int mismatch_count;
   int requests_sent;
   int status_seen [4];
   int cycle_count;

   typed_fit_partition_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_pool_type    (req_pool_type),
      .req_units_needed (req_units_needed),
      .req_owner_id     (req_owner_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_size   (rsp_entry_size),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_fit_strategy (csr_fit_strategy)
   );

   // clock, 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // table layout after reset: large, medium, small pools
   function automatic void reset_table();
      int k;
      for (k = 0; k < DEPTH; k++) begin
         tbl_free[k]  = 1'b1;
         tbl_owner[k] = 16'd0;
         if (k < LARGE_COUNT_DEF) begin
            tbl_pool[k]  = POOL_LARGE;
            tbl_units[k] = LARGE_UNITS;
         end else if (k < LARGE_COUNT_DEF + MEDIUM_COUNT_DEF) begin
            tbl_pool[k]  = POOL_MEDIUM;
            tbl_units[k] = MEDIUM_UNITS;
         end else if (k < LARGE_COUNT_DEF + MEDIUM_COUNT_DEF + SMALL_COUNT_DEF) begin
            tbl_pool[k]  = POOL_SMALL;
            tbl_units[k] = SMALL_UNITS;
         end else begin
            tbl_pool[k]  = POOL_LARGE;
            tbl_units[k] = 6'd0;
         end
      end
      tbl_count = LARGE_COUNT_DEF + MEDIUM_COUNT_DEF + SMALL_COUNT_DEF;
      if (tbl_count > DEPTH) tbl_count = DEPTH;
      fit_mode = FIT_BEST;
   endfunction

   // fold adjacent free entries of equal pool type, closing the gap
   function automatic void coalesce_free_runs();
      int i;
      int j;
      int sum;
      i = 0;
      while (i + 1 < tbl_count) begin
         if (tbl_free[i] && tbl_free[i + 1] && tbl_pool[i] == tbl_pool[i + 1]) begin
            sum = int'(tbl_units[i]) + int'(tbl_units[i + 1]);
            tbl_units[i] = (sum > int'(UNITS_MAX)) ? UNITS_MAX : sum[5:0];
            for (j = i + 1; j + 1 < tbl_count; j++) begin
               tbl_pool[j]  = tbl_pool[j + 1];
               tbl_units[j] = tbl_units[j + 1];
               tbl_free[j]  = tbl_free[j + 1];
               tbl_owner[j] = tbl_owner[j + 1];
            end
            tbl_count--;
         end else begin
            i++;
         end
      end
   endfunction

   // table update and response for one accepted request
   function automatic alloc_result_type apply_request(logic act, logic [1:0] pool,
                                                      logic [5:0] units, logic [15:0] owner);
      alloc_result_type res;
      int  i;
      int  idx;
      bit  found;
      found = 1'b0;
      idx   = 0;
      res.index = 5'd0;
      res.size  = 6'd0;
      if (act == ACT_ALLOC) begin
         for (i = 0; i < tbl_count && i < DEPTH; i++) begin
            if (tbl_free[i] && tbl_pool[i] == pool && tbl_units[i] >= units) begin
               if (!found) begin
                  found = 1'b1;
                  idx   = i;
                  if (fit_mode == FIT_FIRST) break;
               end else if (fit_mode == FIT_BEST) begin
                  if (tbl_units[i] < tbl_units[idx]) idx = i;
               end else begin
                  if (tbl_units[i] > tbl_units[idx]) idx = i;
               end
            end
         end
         if (found) begin
            tbl_free[idx]  = 1'b0;
            tbl_owner[idx] = owner;
            res.status = STAT_ALLOCATED;
            res.index  = idx[4:0];
            res.size   = tbl_units[idx];
         end else begin
            res.status = STAT_NO_FIT;
         end
      end else begin
         for (i = 0; i < tbl_count && i < DEPTH; i++) begin
            if (!tbl_free[i] && owner != 16'd0 && tbl_owner[i] == owner) begin
               found = 1'b1;
               idx   = i;
               break;
            end
         end
         if (found) begin
            res.status = STAT_RELEASED;
            res.index  = idx[4:0];
            res.size   = tbl_units[idx];
            tbl_free[idx]  = 1'b1;
            tbl_owner[idx] = 16'd0;
            coalesce_free_runs();
         end else begin
            res.status = STAT_NO_OWNER;
         end
      end
      return res;
   endfunction

   // offer one request beat, wait for the handshake, record the prediction
   task automatic send_request(input logic act, input logic [1:0] pool,
                               input logic [5:0] units, input logic [15:0] owner);
      alloc_result_type res;
      int q;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_pool_type    <= pool;
      req_units_needed <= units;
      req_owner_id     <= owner;
      do @(posedge clock); while (!req_ready);
      res = apply_request(act, pool, units, owner);
      pending_results.push_back(res);
      requests_sent++;
      if (act == ACT_ALLOC && res.status == STAT_ALLOCATED && owner != 16'd0)
         held_owners.push_back(owner);
      if (act == ACT_RELEASE && res.status == STAT_RELEASED) begin
         for (q = 0; q < held_owners.size(); q++) begin
            if (held_owners[q] == owner) begin
               held_owners.delete(q);
               break;
            end
         end
      end
   endtask

   // stop offering and wait until every predicted beat has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // write the fit strategy register once the block is idle
   task automatic write_strategy(input logic [1:0] code);
      drain_results();
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_fit_strategy <= code;
      do @(posedge clock); while (!csr_ready);
      fit_mode = code;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   // mostly allocate/release pairs on live owners, some noise; pause halfway
   task automatic run_random_requests(input int count);
      int          k;
      int          pick;
      logic [1:0]  pool;
      logic [5:0]  units;
      logic [15:0] owner;
      for (k = 0; k < count; k++) begin
         if (k == count / 2) drain_results();
         if (held_owners.size() == 0 || $urandom_range(0, 99) < 58) begin
            pool = ($urandom_range(0, 99) < 3) ? POOL_NONE : 2'($urandom_range(0, 2));
            pick = $urandom_range(0, 9);
            if (pick < 6) units = 6'($urandom_range(0, 3));
            else if (pick < 9) units = 6'($urandom_range(0, 12));
            else units = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 9) < 7) owner = 16'($urandom_range(1, 24));
            else owner = 16'($urandom_range(1, 65535));
            send_request(ACT_ALLOC, pool, units, owner);
         end else begin
            pick  = $urandom_range(0, 99);
            pool  = 2'($urandom_range(0, 3));
            units = 6'($urandom_range(0, 63));
            if (pick < 88) owner = held_owners[$urandom_range(0, held_owners.size() - 1)];
            else if (pick < 97) owner = 16'($urandom_range(1, 65535));
            else owner = 16'd0;
            send_request(ACT_RELEASE, pool, units, owner);
         end
      end
   endtask

   // extremes of the fields, every status, each fit code and merging
   task automatic test_directed_cases();
      set_idling(32, 73);
      write_strategy(FIT_BEST);
      send_request(ACT_ALLOC,   POOL_LARGE,  6'd0,  16'h0001);
      send_request(ACT_ALLOC,   POOL_MEDIUM, 6'd63, 16'hFFFF);
      send_request(ACT_ALLOC,   POOL_NONE,   6'd0,  16'h0005);
      send_request(ACT_RELEASE, POOL_LARGE,  6'd0,  16'h0000);
      send_request(ACT_RELEASE, POOL_SMALL,  6'd63, 16'h1234);
      send_request(ACT_ALLOC,   POOL_SMALL,  6'd1,  16'hFFFF);
      // an owner of zero pins its entry for good
      send_request(ACT_ALLOC,   POOL_LARGE,  6'd3,  16'h0000);
      // first release folds all free runs of the reset layout
      send_request(ACT_RELEASE, POOL_SMALL,  6'd0,  16'hFFFF);
      send_request(ACT_ALLOC,   POOL_SMALL,  6'd12, 16'hAAAA);
      send_request(ACT_ALLOC,   POOL_SMALL,  6'd13, 16'h5555);
      send_request(ACT_ALLOC,   POOL_MEDIUM, 6'd0,  16'h0002);
      send_request(ACT_RELEASE, POOL_LARGE,  6'd0,  16'h0001);
      write_strategy(FIT_FIRST);
      send_request(ACT_ALLOC,   POOL_LARGE,  6'd1,  16'h0003);
      send_request(ACT_ALLOC,   POOL_LARGE,  6'd1,  16'h0004);
      send_request(ACT_RELEASE, POOL_LARGE,  6'd0,  16'h0003);
      write_strategy(FIT_WORST);
      send_request(ACT_ALLOC,   POOL_LARGE,  6'd0,  16'h0006);
      send_request(ACT_RELEASE, POOL_SMALL,  6'd0,  16'hAAAA);
      send_request(ACT_ALLOC,   POOL_SMALL,  6'd0,  16'h0007);
      write_strategy(FIT_CODE_THREE);
      send_request(ACT_ALLOC,   POOL_LARGE,  6'd2,  16'h0008);
      send_request(ACT_RELEASE, POOL_MEDIUM, 6'd0,  16'h0002);
      send_request(ACT_RELEASE, POOL_LARGE,  6'd0,  16'h0004);
      send_request(ACT_ALLOC,   POOL_MEDIUM, 6'd8,  16'h0009);
   endtask

   task automatic test_best_fit();
      set_idling(32, 73);
      write_strategy(FIT_BEST);
      run_random_requests(390);
   endtask

   // responses held back long enough for the request side to stall
   task automatic test_first_fit_under_hold_off();
      set_idling(32, 73);
      write_strategy(FIT_FIRST);
      hold_off_count++;
      run_random_requests(390);
   endtask

   task automatic test_worst_fit();
      set_idling(73, 32);
      write_strategy(FIT_WORST);
      run_random_requests(390);
   endtask

   task automatic test_spare_fit_code();
      set_idling(73, 32);
      write_strategy(FIT_CODE_THREE);
      run_random_requests(390);
   endtask

   task automatic test_strategy_changes();
      int r;
      set_idling(0, 0);
      for (r = 0; r < 4; r++) begin
         case (r)
            0: write_strategy(FIT_CODE_THREE);
            1: write_strategy(FIT_BEST);
            2: write_strategy(FIT_WORST);
            default: write_strategy(FIT_FIRST);
         endcase
         run_random_requests(95);
      end
   endtask

   // response side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready     = 1'b0;
      hold_off_seen = 0;
      hold_off_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_count != hold_off_seen) begin
            hold_off_seen = hold_off_count;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // compare each response beat with the oldest prediction
   always @(posedge clock) begin : check_beat
      alloc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected response status=%0d index=%0d size=%0d", $realtime,
                        rsp_status, rsp_entry_index, rsp_entry_size);
         end else begin
            want = pending_results.pop_front();
            status_seen[want.status]++;
            if (rsp_status !== want.status || rsp_entry_index !== want.index ||
                rsp_entry_size !== want.size) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: mismatch expected status=%0d index=%0d size=%0d, got %0d %0d %0d",
                           $realtime, want.status, want.index, want.size, rsp_status,
                           rsp_entry_index, rsp_entry_size);
            end
         end
      end
   end

   // test sequence
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_ALLOC;
      req_pool_type    = POOL_LARGE;
      req_units_needed = 6'd0;
      req_owner_id     = 16'd0;
      csr_valid        = 1'b0;
      csr_fit_strategy = FIT_BEST;
      cycle_count      = 0;
      mismatch_count   = 0;
      requests_sent    = 0;
      hold_off_count   = 0;
      status_seen      = '{default: 0};
      set_idling(32, 73);
      reset_table();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_best_fit();
      test_first_fit_under_hold_off();
      test_worst_fit();
      test_spare_fit_code();
      test_strategy_changes();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests over best, first, worst and spare fit codes, random gaps",
               requests_sent);
      $display("beats: %0d allocated, %0d no fit, %0d released, %0d owner not found",
               status_seen[STAT_ALLOCATED], status_seen[STAT_NO_FIT],
               status_seen[STAT_RELEASED], status_seen[STAT_NO_OWNER]);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- typed_fit_partition_allocator.f -----
hw/rtl/tfpa_pkg.sv
hw/rtl/typed_fit_partition_allocator.sv
bench/tb_typed_fit_partition_allocator.sv
